[hdl/papm_pkg.sv]
// Package: shared payload, command and status types for the polygon measurement block.
`default_nettype none

package papm_pkg;

  localparam int COORD_W     = 24;
  localparam int AREA_W      = 57;
  localparam int PERIM_W     = 35;
  localparam int COUNT_OUT_W = 11;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      last_vertex;
  } papm_vtx_t;

  typedef struct packed {
    logic [AREA_W-1:0]         area;
    logic [PERIM_W-1:0]        perimeter;
    logic signed [COORD_W-1:0] mean_x;
    logic signed [COORD_W-1:0] mean_y;
    logic [COUNT_OUT_W-1:0]    vertex_count;
    logic                      overflow;
  } papm_res_t;

  // products formed by the shared multiplier, in issue order
  typedef enum logic [1:0] {
    MUL_AXBY,
    MUL_BXAY,
    MUL_DXDX,
    MUL_DYDY
  } mul_op_t;

  typedef struct packed {
    logic    load_in;
    logic    set_ovf;
    logic    take_first;
    logic    commit;
    logic    closing;
    logic    mul_en;
    mul_op_t mul_op;
    logic    acc_en;
    mul_op_t acc_op;
    logic    sqrt_start;
    logic    len_add;
    logic    div_start;
    logic    load_out;
    logic    clear;
  } papm_cmd_t;

  typedef struct packed {
    logic cnt_full;
    logic cnt_zero;
    logic last;
    logic sqrt_done;
    logic div_done;
  } papm_sts_t;

endpackage

`default_nettype wire

[hdl/papm_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module papm_isqrt #(
  parameter int RAD_W = 50
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [RAD_W-1:0]   radicand,
  output logic                    done,
  output logic [RAD_W/2-1:0]      root
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  rem_next;
  logic [ROOT_W-1:0] root_next;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_comb begin
    if (rem_sh >= trial) begin
      rem_next  = rem_sh - trial;
      root_next = {root[ROOT_W-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh;
      root_next = {root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

`default_nettype wire

[hdl/papm_div.sv]
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none

module papm_div #(
  parameter int N_W = 35,
  parameter int D_W = 11
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic                done,
  output logic [N_W-1:0]      quotient
);

  localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

  logic [D_W-1:0]   dsr;
  logic [D_W-1:0]   rem;
  logic [D_W:0]     rem_sh;
  logic [D_W:0]     diff;
  logic             ge;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign rem_sh = {rem, quotient[N_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign ge     = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[N_W-2:0], ge};
      rem      <= ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/papm_datapath.sv]
// Datapath: vertex registers, shared multiplier, accumulators, root and mean units.
`default_nettype none

module papm_datapath #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  papm_pkg::papm_vtx_t vtx,
  input  papm_pkg::papm_cmd_t cmd,
  output papm_pkg::papm_sts_t sts,
  output papm_pkg::papm_res_t res
);

  import papm_pkg::*;

  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int OPND_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * OPND_W;
  localparam int RAD_W   = PROD_W;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int CROSS_W = 2 * COORD_W + 1 + CNT_W;
  localparam int SUM_W   = COORD_W + CNT_W;

  logic signed [COORD_W-1:0] cur_x, cur_y, first_x, first_y, prev_x, prev_y;
  logic                      cur_last;
  logic signed [COORD_W-1:0] b_x, b_y;
  logic signed [OPND_W-1:0]  ax_e, ay_e, bx_e, by_e, dx, dy, op1, op2;
  logic signed [PROD_W-1:0]  prod;
  logic [RAD_W-1:0]          rad;
  logic [ROOT_W-1:0]         root;
  logic                      sqrt_done;
  logic signed [CROSS_W-1:0] cross_sum;
  logic [CROSS_W-1:0]        cross_abs;
  logic [CROSS_W+AREA_W-1:0] half_wide;
  logic [AREA_W-1:0]         area_next, area_sat;
  logic [PERIM_W-1:0]        length_sum;
  logic [PERIM_W:0]          len_total;
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic [SUM_W-1:0]          mag_x, mag_y, q_x, q_y;
  logic                      done_x, done_y, neg_x, neg_y;
  logic [CNT_W-1:0]          count;
  logic [CNT_W+COUNT_OUT_W-1:0] count_wide;
  logic                      overflow_flag;
  logic [COORD_W-1:0]        mean_x, mean_y;

  assign b_x  = cmd.closing ? first_x : cur_x;
  assign b_y  = cmd.closing ? first_y : cur_y;
  assign ax_e = {prev_x[COORD_W-1], prev_x};
  assign ay_e = {prev_y[COORD_W-1], prev_y};
  assign bx_e = {b_x[COORD_W-1], b_x};
  assign by_e = {b_y[COORD_W-1], b_y};
  assign dx   = ax_e - bx_e;
  assign dy   = ay_e - by_e;

  always_comb begin
    case (cmd.mul_op)
      MUL_AXBY: begin op1 = ax_e; op2 = by_e; end
      MUL_BXAY: begin op1 = bx_e; op2 = ay_e; end
      MUL_DXDX: begin op1 = dx;   op2 = dx;   end
      MUL_DYDY: begin op1 = dy;   op2 = dy;   end
      default:  begin op1 = dx;   op2 = dy;   end
    endcase
  end

  // area = |cross| / 2, saturated to the output width
  assign cross_abs = cross_sum[CROSS_W-1] ? (~cross_sum + 1'b1) : cross_sum;
  assign half_wide = {{AREA_W{1'b0}}, cross_abs} >> 1;
  assign area_next = (|half_wide[CROSS_W+AREA_W-1:AREA_W]) ? {AREA_W{1'b1}}
                                                          : half_wide[AREA_W-1:0];

  assign len_total = {1'b0, length_sum} + (PERIM_W+1)'(root);

  assign mag_x = sum_x[SUM_W-1] ? (~sum_x + 1'b1) : sum_x;
  assign mag_y = sum_y[SUM_W-1] ? (~sum_y + 1'b1) : sum_y;
  assign mean_x = neg_x ? (~q_x[COORD_W-1:0] + 1'b1) : q_x[COORD_W-1:0];
  assign mean_y = neg_y ? (~q_y[COORD_W-1:0] + 1'b1) : q_y[COORD_W-1:0];
  assign count_wide = {{COUNT_OUT_W{1'b0}}, count};

  papm_isqrt #(.RAD_W(RAD_W)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (rad),
    .done     (sqrt_done),
    .root     (root)
  );

  papm_div #(.N_W(SUM_W), .D_W(CNT_W)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag_x),
    .divisor  (count),
    .done     (done_x),
    .quotient (q_x)
  );

  papm_div #(.N_W(SUM_W), .D_W(CNT_W)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag_y),
    .divisor  (count),
    .done     (done_y),
    .quotient (q_y)
  );

  assign sts.cnt_full  = (count == CNT_W'(MAX_VERTICES));
  assign sts.cnt_zero  = (count == '0);
  assign sts.last      = cur_last;
  assign sts.sqrt_done = sqrt_done;
  assign sts.div_done  = done_x & done_y;

  // polygon state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cross_sum     <= '0;
      length_sum    <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      count         <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (cmd.set_ovf) begin
        overflow_flag <= 1'b1;
      end
      if (cmd.acc_en) begin
        case (cmd.acc_op)
          MUL_AXBY: cross_sum <= cross_sum + CROSS_W'(prod);
          MUL_BXAY: cross_sum <= cross_sum - CROSS_W'(prod);
          default:  cross_sum <= cross_sum;
        endcase
      end
      if (cmd.len_add) begin
        length_sum <= len_total[PERIM_W] ? {PERIM_W{1'b1}} : len_total[PERIM_W-1:0];
      end
      if (cmd.commit) begin
        sum_x <= sum_x + SUM_W'(cur_x);
        sum_y <= sum_y + SUM_W'(cur_y);
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_x    <= vtx.vertex_x;
      cur_y    <= vtx.vertex_y;
      cur_last <= vtx.last_vertex;
    end
    if (cmd.take_first) begin
      first_x <= cur_x;
      first_y <= cur_y;
    end
    if (cmd.commit) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (cmd.mul_en) begin
      prod <= op1 * op2;
    end
    if (cmd.acc_en) begin
      case (cmd.acc_op)
        MUL_DXDX: rad <= prod;
        MUL_DYDY: rad <= rad + prod;
        default:  rad <= rad;
      endcase
    end
    if (cmd.div_start) begin
      neg_x <= sum_x[SUM_W-1];
      neg_y <= sum_y[SUM_W-1];
    end
    area_sat <= area_next;
    if (cmd.load_out) begin
      res.area         <= area_sat;
      res.perimeter    <= length_sum;
      res.mean_x       <= mean_x;
      res.mean_y       <= mean_y;
      res.vertex_count <= count_wide[COUNT_OUT_W-1:0];
      res.overflow     <= overflow_flag;
    end
  end

endmodule

`default_nettype wire

[hdl/papm_ctrl.sv]
// Controller: sequences each vertex through the edge, root and mean steps.
`default_nettype none

module papm_ctrl (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       vtx_valid,
  output logic            vtx_ready,
  output logic            res_valid,
  input  wire logic       res_ready,
  input  papm_pkg::papm_sts_t sts,
  output papm_pkg::papm_cmd_t cmd
);

  import papm_pkg::*;

  localparam int MUL_STEPS = 5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_SQ_START,
    S_SQ_WAIT,
    S_ADD,
    S_DIV_START,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  state_t     state, state_next;
  logic [2:0] step, step_next;
  logic       closing, closing_next;
  logic       res_valid_next;

  assign vtx_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.closing    = closing;
    state_next     = state;
    step_next      = step;
    closing_next   = closing;

    case (state)
      S_IDLE: begin
        if (vtx_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.cnt_full || sts.cnt_zero) begin
          cmd.set_ovf    = sts.cnt_full;
          cmd.take_first = !sts.cnt_full;
          cmd.commit     = !sts.cnt_full;
          if (sts.last) begin
            closing_next = 1'b1;
            step_next    = '0;
            state_next   = S_MUL;
          end else begin
            state_next   = S_IDLE;
          end
        end else begin
          closing_next = 1'b0;
          step_next    = '0;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = (step < 3'(MUL_STEPS - 1));
        cmd.acc_en = (step != '0);
        case (step)
          3'd0:    begin cmd.mul_op = MUL_AXBY; cmd.acc_op = MUL_AXBY; end
          3'd1:    begin cmd.mul_op = MUL_BXAY; cmd.acc_op = MUL_AXBY; end
          3'd2:    begin cmd.mul_op = MUL_DXDX; cmd.acc_op = MUL_BXAY; end
          3'd3:    begin cmd.mul_op = MUL_DYDY; cmd.acc_op = MUL_DXDX; end
          default: begin cmd.mul_op = MUL_DYDY; cmd.acc_op = MUL_DYDY; end
        endcase
        step_next = step + 1'b1;
        if (step == 3'(MUL_STEPS - 1)) begin
          state_next = S_SQ_START;
        end
      end
      S_SQ_START: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (sts.sqrt_done) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.len_add = 1'b1;
        if (closing) begin
          state_next = S_DIV_START;
        end else begin
          cmd.commit = 1'b1;
          if (sts.last) begin
            closing_next = 1'b1;
            step_next    = '0;
            state_next   = S_MUL;
          end else begin
            state_next   = S_IDLE;
          end
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!res_valid || res_ready) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          closing_next = 1'b0;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      closing   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      closing   <= closing_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

`default_nettype wire

[hdl/polygon_area_perimeter_mean.sv]
// Top level: streaming polygon area, perimeter and vertex mean.
//
// Vertex requests (vtx_valid/vtx_ready, payload vtx) carry one Q12.12 vertex
// each; last_vertex closes the polygon. One result request per polygon leaves
// on res_valid/res_ready with area, perimeter, mean x/y, count and overflow.
// The block works on one vertex at a time:
//   - ordinary vertex: accept, decode, 5 shared-multiplier steps for the
//     cross and squared terms, start and finish the bit-serial square root,
//     then add the edge length
//   - first vertex or one past MAX_VERTICES: accept and decode only
//   - last vertex: its own edge, then the closing edge, then the two
//     bit-serial mean dividers (one bit of the 35-bit sum per cycle) and
//     the result load
// The result sits in an output register; new vertices are taken while it
// waits. A stalled receiver only holds the block once the next polygon's
// result is ready. Reset (rst, synchronous) empties the block and drops any
// pending result; no clearing pass is needed.
`default_nettype none

module polygon_area_perimeter_mean #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       vtx_valid,
  output logic            vtx_ready,
  input  papm_pkg::papm_vtx_t vtx,
  output logic            res_valid,
  input  wire logic       res_ready,
  output papm_pkg::papm_res_t res
);

  import papm_pkg::*;

  papm_cmd_t cmd;
  papm_sts_t sts;

  papm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  papm_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
    .clk (clk),
    .rst (rst),
    .vtx (vtx),
    .cmd (cmd),
    .sts (sts),
    .res (res)
  );

endmodule

`default_nettype wire

[hdl/papm_checker.sv]
// Checker: port-level assertions for the polygon measurement block, with its bind.
`default_nettype none

module papm_checker #(
  parameter int MAX_VERTICES = 1024
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       vtx_valid,
  input wire logic       vtx_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input papm_pkg::papm_res_t res
);

  import papm_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result request dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res))
    else $error("result payload changed while stalled");

  a_one_vertex: assert property (@(posedge clk) disable iff (rst)
    vtx_valid && vtx_ready |=> !vtx_ready)
    else $error("vertex taken while previous vertex still in work");

  a_ovf_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.overflow |-> res.vertex_count == COUNT_OUT_W'(MAX_VERTICES))
    else $error("overflow flagged without a saturated count");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result pending after reset");

endmodule

bind polygon_area_perimeter_mean papm_checker #(.MAX_VERTICES(MAX_VERTICES)) u_papm_checker (
  .clk       (clk),
  .rst       (rst),
  .vtx_valid (vtx_valid),
  .vtx_ready (vtx_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

`default_nettype wire

[sim/polygon_area_perimeter_mean_tb.sv]
`timescale 1ns / 100ps
// Testbench: polygon area/perimeter/mean block checked by a self-contained scoreboard.

module polygon_area_perimeter_mean_tb;
  import papm_pkg::*;

  localparam int MAX_VTX = 1024;
  localparam int TARGET_ITEMS = 1650;
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam longint unsigned AREA_MAX = (64'd1 << AREA_W) - 1;
  localparam longint unsigned PERIM_MAX = (64'd1 << PERIM_W) - 1;

  class papm_scoreboard;
    longint first_x, first_y, prev_x, prev_y;
    longint sum_x, sum_y;
    longint unsigned cross_acc, perim_acc;
    int unsigned n_vtx;
    bit ovf;
    papm_res_t expected_q[$];
    int unsigned errors;

    function new();
      clear_polygon();
      errors = 0;
    endfunction

    function void clear_polygon();
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      sum_x = 0; sum_y = 0;
      cross_acc = 0; perim_acc = 0;
      n_vtx = 0;
      ovf = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, probe, rem;
      rem = v;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem -= root + probe;
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    // deltas of 24-bit coordinates keep the radicand below 2^50, so no squaring saturation
    function void add_edge(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      longint unsigned len;
      cross_acc += ax * by - bx * ay;
      dx = ax - bx;
      dy = ay - by;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      len = int_sqrt(dx * dx + dy * dy);
      if (perim_acc > PERIM_MAX - len) perim_acc = PERIM_MAX;
      else perim_acc += len;
    endfunction

    function logic signed [COORD_W-1:0] mean_of(longint s, int unsigned n);
      longint unsigned q;
      q = (s < 0) ? longint'(-s) : longint'(s);
      q = q / n;
      if (s < 0) q = 0 - q;
      return q[COORD_W-1:0];
    endfunction

    function void note_vertex(papm_vtx_t v);
      longint x, y;
      longint unsigned c, a;
      papm_res_t e;
      x = longint'($signed(v.vertex_x));
      y = longint'($signed(v.vertex_y));
      if (n_vtx >= MAX_VTX) begin
        ovf = 1;
      end else begin
        if (n_vtx == 0) begin
          first_x = x;
          first_y = y;
        end else begin
          add_edge(prev_x, prev_y, x, y);
        end
        prev_x = x;
        prev_y = y;
        sum_x += x;
        sum_y += y;
        n_vtx++;
      end
      if (!v.last_vertex) return;
      add_edge(prev_x, prev_y, first_x, first_y);
      c = cross_acc;
      if (c[63]) c = 0 - c;
      a = c >> 1;
      if (a > AREA_MAX) a = AREA_MAX;
      e.area = a[AREA_W-1:0];
      e.perimeter = perim_acc[PERIM_W-1:0];
      e.mean_x = mean_of(sum_x, n_vtx);
      e.mean_y = mean_of(sum_y, n_vtx);
      e.vertex_count = n_vtx[COUNT_OUT_W-1:0];
      e.overflow = ovf;
      expected_q.push_back(e);
      clear_polygon();
    endfunction

    function void check_result(papm_res_t r);
      papm_res_t e;
      if (expected_q.size() == 0) begin
        $error("result request with no polygon pending");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r.area !== e.area) begin
        $error("area expected %0d got %0d", e.area, r.area);
        errors++;
      end
      if (r.perimeter !== e.perimeter) begin
        $error("perimeter expected %0d got %0d", e.perimeter, r.perimeter);
        errors++;
      end
      if (r.mean_x !== e.mean_x) begin
        $error("mean_x expected %0d got %0d", e.mean_x, r.mean_x);
        errors++;
      end
      if (r.mean_y !== e.mean_y) begin
        $error("mean_y expected %0d got %0d", e.mean_y, r.mean_y);
        errors++;
      end
      if (r.vertex_count !== e.vertex_count) begin
        $error("vertex_count expected %0d got %0d", e.vertex_count, r.vertex_count);
        errors++;
      end
      if (r.overflow !== e.overflow) begin
        $error("overflow expected %0d got %0d", e.overflow, r.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic vtx_valid;
  logic vtx_ready;
  papm_vtx_t vtx;
  logic res_valid;
  logic res_ready;
  papm_res_t res;

  papm_scoreboard sb;
  int unsigned sent;
  bit no_gaps;

  polygon_area_perimeter_mean #(
    .MAX_VERTICES(MAX_VTX)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .vtx_valid(vtx_valid),
    .vtx_ready(vtx_ready),
    .vtx(vtx),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // 0: full range, 1: near the origin, 2: mostly extremes
  function automatic logic signed [COORD_W-1:0] pick_coord(int mode);
    logic [31:0] r;
    int v;
    r = $urandom;
    v = int'($urandom_range(0, 65535)) - 32768;
    case (mode)
      0: return r[COORD_W-1:0];
      1: return v[COORD_W-1:0];
      default: begin
        case ($urandom_range(0, 4))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          3: return '1;
          default: return r[COORD_W-1:0];
        endcase
      end
    endcase
  endfunction

  task automatic send_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic last);
    int g;
    g = no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (g > 0) begin
      vtx_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    vtx_valid <= 1'b1;
    vtx <= '{vertex_x: x, vertex_y: y, last_vertex: last};
    @(posedge clk);
    while (!vtx_ready) @(posedge clk);
    sb.note_vertex(vtx);
    sent++;
  endtask

  task automatic send_polygon(int n, int mode);
    for (int i = 0; i < n; i++) send_vertex(pick_coord(mode), pick_coord(mode), i == n - 1);
  endtask

  initial begin
    bit big_done;
    int r;
    int n;
    sb = new();
    rst = 1'b1;
    vtx_valid = 1'b0;
    vtx = '0;
    sent = 0;
    no_gaps = 0;
    big_done = 0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // single-vertex polygons
    send_vertex(C_MAX, C_MIN, 1'b1);
    send_vertex('1, '1, 1'b1);
    // triangle spanning the full coordinate range
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b1);
    // unit square, counterclockwise then clockwise
    send_vertex(0, 0, 1'b0);
    send_vertex(4096, 0, 1'b0);
    send_vertex(4096, 4096, 1'b0);
    send_vertex(0, 4096, 1'b1);
    send_vertex(0, 0, 1'b0);
    send_vertex(0, 4096, 1'b0);
    send_vertex(4096, 4096, 1'b0);
    send_vertex(4096, 0, 1'b1);
    // collinear, zero area
    send_vertex(-100, -100, 1'b0);
    send_vertex(0, 0, 1'b0);
    send_vertex(100, 100, 1'b1);
    // two vertices at opposite corners
    send_vertex(C_MIN, C_MAX, 1'b0);
    send_vertex(C_MAX, C_MIN, 1'b1);
    // negative mean, truncation toward zero
    send_vertex(-5, -7, 1'b0);
    send_vertex(-2, -1, 1'b0);
    send_vertex(-3, 1, 1'b1);

    while (sent < TARGET_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (!big_done && sent > 400) begin
        // more than MAX_VTX vertices: the tail is dropped and overflow set
        send_polygon($urandom_range(MAX_VTX + 1, MAX_VTX + 3), $urandom_range(0, 2));
        big_done = 1;
      end else begin
        r = $urandom_range(0, 9);
        n = (r < 2) ? $urandom_range(1, 2) : $urandom_range(3, 12);
        send_polygon(n, $urandom_range(0, 2));
      end
    end
    @(negedge clk) vtx_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS polygon_area_perimeter_mean");
    end else begin
      $display("FAIL polygon_area_perimeter_mean");
    end
    $finish;
  end

  initial begin
    int lo;
    res_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      res_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      lo = pick_gap();
      if (lo > 0) begin
        res_ready <= 1'b0;
        repeat (lo) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_result(res);
  end

  initial begin
    #20_000_000;
    $display("FAIL polygon_area_perimeter_mean");
    $finish;
  end

endmodule
